>>> rtl/core/fel_pkg.sv
package fel_pkg;

    // operation codes
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_USE   = 2'd1;
    localparam logic [1:0] OP_FIND  = 2'd2;
    localparam logic [1:0] OP_QUERY = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_CONFLICT  = 3'd2;
    localparam logic [2:0] ST_TOO_LARGE = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    localparam int START_W  = 32;
    localparam int LEN_W    = 32;
    localparam int AMT_W    = 16;
    localparam int COUNT_W  = 7;

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CMP   = 6'b000010,
        S_SEL   = 6'b000100,
        S_EXEC  = 6'b001000,
        S_APPLY = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    // per-cell update control
    typedef struct packed {
        logic ld;
        logic shr;
        logic shl;
    } cell_ctl_t;

    // table change decided for one request
    typedef struct packed {
        logic ins;
        logic rem;
        logic wr_pos;
        logic wr_prev;
    } tbl_cmd_t;

endpackage

>>> rtl/core/fel_cell.sv
module fel_cell
(
    input  logic                              clk,
    input  fel_pkg::cell_ctl_t                ctl,
    input  logic [fel_pkg::START_W-1:0]       ld_start,
    input  logic [fel_pkg::LEN_W-1:0]         ld_len,
    input  logic [fel_pkg::START_W-1:0]       left_start,
    input  logic [fel_pkg::LEN_W-1:0]         left_len,
    input  logic [fel_pkg::START_W-1:0]       right_start,
    input  logic [fel_pkg::LEN_W-1:0]         right_len,
    input  logic                              valid,
    input  logic [fel_pkg::START_W-1:0]       req,
    input  logic [fel_pkg::AMT_W-1:0]         amt,
    output logic [fel_pkg::START_W-1:0]       start,
    output logic [fel_pkg::LEN_W-1:0]         len,
    output logic                              lt,
    output logic                              eq,
    output logic                              fit
);

    logic [fel_pkg::START_W-1:0] start_reg;
    logic [fel_pkg::LEN_W-1:0]   len_reg;

    // entry update: load, take from left, take from right
    always_ff @(posedge clk)
    begin
        if (ctl.ld)
        begin
            start_reg <= ld_start;
            len_reg   <= ld_len;
        end
        else if (ctl.shr)
        begin
            start_reg <= left_start;
            len_reg   <= left_len;
        end
        else if (ctl.shl)
        begin
            start_reg <= right_start;
            len_reg   <= right_len;
        end
    end

    assign start = start_reg;
    assign len   = len_reg;

    // local compares against the broadcast request
    assign lt  = valid && (start_reg < req);
    assign eq  = valid && (start_reg == req);
    assign fit = valid && (len_reg >= {{(fel_pkg::LEN_W-fel_pkg::AMT_W){1'b0}}, amt});

endmodule

>>> rtl/core/free_extent_list.sv
// free extent list: a sorted table of (start, length) extents held in a
// row of cells, one extent per cell, neighbors shifting on insert/remove.
// input channel: in_valid/in_stall with operation, start_req, amount.
// output channel: out_valid/out_stall with status, found_start,
// found_length, entry_count; one result per request.
// each request goes through these steps after acceptance: compare in
// every cell, select neighbors, decide, update the row, then present the
// result. one request is in flight at a time; in_stall is high from
// acceptance until the result is loaded, so a new request cannot be
// accepted until the result of the last one is loaded.
// a result that is stalled holds in the output register; a new request can
// be accepted meanwhile, and its result waits in the sequencer until the
// output register frees.
// the mode register lies at byte address 0 of the apb port.
// reset empties the table (count to zero) and sets mode to sequential;
// entry contents are not cleared.
module free_extent_list
#(
    parameter int ENTRIES = 64
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        operation,
    input  logic [fel_pkg::START_W-1:0]       start_req,
    input  logic [fel_pkg::AMT_W-1:0]         amount,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [2:0]                        status,
    output logic [fel_pkg::START_W-1:0]       found_start,
    output logic [fel_pkg::LEN_W-1:0]         found_length,
    output logic [fel_pkg::COUNT_W-1:0]       entry_count
);

    localparam int CW = $clog2(ENTRIES + 1);
    localparam int SW = fel_pkg::START_W;
    localparam int LW = fel_pkg::LEN_W;
    localparam int AW = fel_pkg::AMT_W;

    fel_pkg::state_t state_reg, state_next;
    logic            mode_reg;
    logic [CW-1:0]   count_reg;

    logic [1:0]      op_reg;
    logic [SW-1:0]   req_reg;
    logic [AW-1:0]   amt_reg;

    logic [ENTRIES-1:0] lt_vec, eq_vec, fit_vec, lt_run;
    logic [ENTRIES-1:0] lt_reg, eq_reg, fit_reg;
    logic [ENTRIES-1:0] valid_vec, pos_oh, prev_oh, fit_oh, after_vec;

    logic [SW-1:0] cell_start [ENTRIES];
    logic [LW-1:0] cell_len   [ENTRIES];
    fel_pkg::cell_ctl_t cell_ctl [ENTRIES];

    // selected neighbors
    logic [SW-1:0] nx_s, pv_s, ft_s;
    logic [LW-1:0] nx_l, pv_l;
    logic [SW-1:0] nx_s_reg, pv_s_reg, ft_s_reg;
    logic [LW-1:0] nx_l_reg, pv_l_reg;
    logic          has_next_reg, has_prev_reg, eq_any_reg, fit_any_reg;

    // decision
    fel_pkg::tbl_cmd_t cmd, cmd_reg;
    logic [SW-1:0] ld_s, ld_s_reg;
    logic [LW-1:0] ld_l, ld_l_reg;
    logic [2:0]    res_st, res_st_reg;
    logic [SW-1:0] res_fs, res_fs_reg;
    logic [LW-1:0] res_fl, res_fl_reg;
    logic [CW-1:0] res_cnt, res_cnt_reg;

    logic          out_valid_reg;
    logic [2:0]    status_reg;
    logic [SW-1:0] found_start_reg;
    logic [LW-1:0] found_length_reg;
    logic [CW+6:0] cnt_ext;
    logic [fel_pkg::COUNT_W-1:0] entry_count_reg;

    logic          in_acc, out_free, cfg_wr;

    // configuration port
    assign pready = 1'b1;
    assign prdata = {31'd0, mode_reg};
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b1;
        else if (cfg_wr)
            mode_reg <= pwdata[0];
    end

    // handshake
    assign in_stall = (state_reg != fel_pkg::S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // row of cells
    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++)
        begin : g_cell
            logic [SW-1:0] l_s, r_s;
            logic [LW-1:0] l_l, r_l;
            if (gi == 0)
            begin : g_first
                assign l_s = '0;
                assign l_l = '0;
            end
            else
            begin : g_mid
                assign l_s = cell_start[gi-1];
                assign l_l = cell_len[gi-1];
            end
            if (gi == ENTRIES - 1)
            begin : g_last
                assign r_s = '0;
                assign r_l = '0;
                assign prev_oh[gi] = lt_reg[gi];
            end
            else
            begin : g_inner
                assign r_s = cell_start[gi+1];
                assign r_l = cell_len[gi+1];
                assign prev_oh[gi] = lt_reg[gi] && !lt_reg[gi+1];
            end
            if (gi == 0)
            begin : g_pos0
                assign pos_oh[gi] = !lt_reg[gi];
            end
            else
            begin : g_posn
                assign pos_oh[gi] = !lt_reg[gi] && lt_reg[gi-1];
            end
            assign valid_vec[gi] = (CW'(gi) < count_reg);
            assign after_vec[gi] = !lt_reg[gi] && !pos_oh[gi];

            // only the unbroken run of lower starts from the front counts,
            // a wrapped start can leave the row out of order
            assign lt_run[gi] = &lt_vec[gi:0];

            // update control from the decided command
            always_comb
            begin
                cell_ctl[gi].ld  = (state_reg == fel_pkg::S_APPLY) &&
                                   (((cmd_reg.ins || cmd_reg.wr_pos) && pos_oh[gi]) ||
                                    (cmd_reg.wr_prev && prev_oh[gi]));
                cell_ctl[gi].shr = (state_reg == fel_pkg::S_APPLY) && cmd_reg.ins &&
                                   after_vec[gi];
                cell_ctl[gi].shl = (state_reg == fel_pkg::S_APPLY) && cmd_reg.rem &&
                                   !lt_reg[gi];
            end

            fel_cell u_cell
            (
                .clk         (clk),
                .ctl         (cell_ctl[gi]),
                .ld_start    (ld_s_reg),
                .ld_len      (ld_l_reg),
                .left_start  (l_s),
                .left_len    (l_l),
                .right_start (r_s),
                .right_len   (r_l),
                .valid       (valid_vec[gi]),
                .req         (req_reg),
                .amt         (amt_reg),
                .start       (cell_start[gi]),
                .len         (cell_len[gi]),
                .lt          (lt_vec[gi]),
                .eq          (eq_vec[gi]),
                .fit         (fit_vec[gi])
            );
        end
    endgenerate

    // lowest fitting entry
    assign fit_oh = fit_reg & (~fit_reg + ENTRIES'(1));

    // and-or selection of neighbors and first fit
    always_comb
    begin
        nx_s = '0;
        nx_l = '0;
        pv_s = '0;
        pv_l = '0;
        ft_s = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            nx_s = nx_s | (cell_start[i] & {SW{pos_oh[i]}});
            nx_l = nx_l | (cell_len[i]   & {LW{pos_oh[i]}});
            pv_s = pv_s | (cell_start[i] & {SW{prev_oh[i]}});
            pv_l = pv_l | (cell_len[i]   & {LW{prev_oh[i]}});
            ft_s = ft_s | (cell_start[i] & {SW{fit_oh[i]}});
        end
    end

    // operation decision
    always_comb
    begin
        logic [SW:0]   end_a, prev_end;
        logic [LW+1:0] sum;
        logic          mrg_n, mrg_p;
        logic [LW-1:0] newl;

        end_a    = {1'b0, req_reg} + {{(SW+1-AW){1'b0}}, amt_reg};
        prev_end = {1'b0, pv_s_reg} + {{(SW+1-LW){1'b0}}, pv_l_reg};
        mrg_n    = has_next_reg && ({1'b0, nx_s_reg} == end_a);
        mrg_p    = has_prev_reg && (prev_end == {1'b0, req_reg});
        newl     = nx_l_reg - {{(LW-AW){1'b0}}, amt_reg};
        sum      = '0;
        cmd      = '0;
        ld_s     = req_reg;
        ld_l     = '0;
        res_st   = fel_pkg::ST_OK;
        res_fs   = '0;
        res_fl   = '0;
        res_cnt  = count_reg;
        case (op_reg)
            fel_pkg::OP_ADD:
            begin
                if (has_next_reg && nx_s_reg == req_reg)
                    res_st = fel_pkg::ST_CONFLICT;
                else if (mode_reg && ((has_next_reg && {1'b0, nx_s_reg} < end_a) ||
                                      (has_prev_reg && prev_end > {1'b0, req_reg})))
                    res_st = fel_pkg::ST_CONFLICT;
                else if (mode_reg && mrg_p)
                begin
                    cmd.wr_prev = 1'b1;
                    ld_s = pv_s_reg;
                    if (mrg_n)
                    begin
                        sum = {2'b0, pv_l_reg} + {{(LW+2-AW){1'b0}}, amt_reg}
                            + {2'b0, nx_l_reg};
                        cmd.rem = 1'b1;
                        res_cnt = count_reg - CW'(1);
                    end
                    else
                        sum = {2'b0, pv_l_reg} + {{(LW+2-AW){1'b0}}, amt_reg};
                    ld_l = (sum[LW+1:LW] != 2'b00) ? {LW{1'b1}} : sum[LW-1:0];
                end
                else if (mode_reg && mrg_n)
                begin
                    cmd.wr_pos = 1'b1;
                    sum = {2'b0, nx_l_reg} + {{(LW+2-AW){1'b0}}, amt_reg};
                    ld_l = (sum[LW+1:LW] != 2'b00) ? {LW{1'b1}} : sum[LW-1:0];
                end
                else if (count_reg >= CW'(ENTRIES))
                    res_st = fel_pkg::ST_FULL;
                else
                begin
                    cmd.ins = 1'b1;
                    ld_l = {{(LW-AW){1'b0}}, amt_reg};
                    res_cnt = count_reg + CW'(1);
                end
            end
            fel_pkg::OP_USE:
            begin
                if (!eq_any_reg)
                    res_st = fel_pkg::ST_NOT_FOUND;
                else if (nx_l_reg < {{(LW-AW){1'b0}}, amt_reg})
                    res_st = fel_pkg::ST_TOO_LARGE;
                else
                begin
                    res_fl = newl;
                    ld_l   = newl;
                    if (mode_reg && newl == '0)
                    begin
                        cmd.rem = 1'b1;
                        res_cnt = count_reg - CW'(1);
                    end
                    else
                    begin
                        cmd.wr_pos = 1'b1;
                        ld_s = mode_reg ? (nx_s_reg + {{(SW-AW){1'b0}}, amt_reg}) : nx_s_reg;
                    end
                end
            end
            fel_pkg::OP_FIND:
            begin
                if (fit_any_reg)
                    res_fs = ft_s_reg;
                else
                    res_st = fel_pkg::ST_NOT_FOUND;
            end
            default:
            begin
                if (eq_any_reg)
                    res_fl = nx_l_reg;
                else
                    res_st = fel_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fel_pkg::S_IDLE:  if (in_acc) state_next = fel_pkg::S_CMP;
            fel_pkg::S_CMP:   state_next = fel_pkg::S_SEL;
            fel_pkg::S_SEL:   state_next = fel_pkg::S_EXEC;
            fel_pkg::S_EXEC:  state_next = fel_pkg::S_APPLY;
            fel_pkg::S_APPLY: state_next = fel_pkg::S_DONE;
            fel_pkg::S_DONE:  if (out_free) state_next = fel_pkg::S_IDLE;
            default:          state_next = fel_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fel_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == fel_pkg::S_APPLY)
                count_reg <= res_cnt_reg;
            if (state_reg == fel_pkg::S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op_reg  <= operation;
            req_reg <= start_req;
            amt_reg <= amount;
        end
        if (state_reg == fel_pkg::S_CMP)
        begin
            lt_reg  <= lt_run;
            eq_reg  <= eq_vec;
            fit_reg <= fit_vec;
        end
        if (state_reg == fel_pkg::S_SEL)
        begin
            nx_s_reg     <= nx_s;
            nx_l_reg     <= nx_l;
            pv_s_reg     <= pv_s;
            pv_l_reg     <= pv_l;
            ft_s_reg     <= ft_s;
            has_next_reg <= |(pos_oh & valid_vec);
            has_prev_reg <= |lt_reg;
            eq_any_reg   <= |(eq_reg & pos_oh);
            fit_any_reg  <= |fit_reg;
        end
        if (state_reg == fel_pkg::S_EXEC)
        begin
            cmd_reg     <= cmd;
            ld_s_reg    <= ld_s;
            ld_l_reg    <= ld_l;
            res_st_reg  <= res_st;
            res_fs_reg  <= res_fs;
            res_fl_reg  <= res_fl;
            res_cnt_reg <= res_cnt;
        end
        if (state_reg == fel_pkg::S_DONE && out_free)
        begin
            status_reg       <= res_st_reg;
            found_start_reg  <= res_fs_reg;
            found_length_reg <= res_fl_reg;
            entry_count_reg  <= cnt_ext[fel_pkg::COUNT_W-1:0];
        end
    end

    assign cnt_ext = {7'd0, count_reg};

    // command only takes effect in the update cycle
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign found_start  = found_start_reg;
    assign found_length = found_length_reg;
    assign entry_count  = entry_count_reg;

endmodule

>>> bench/fel_checker.sv
`timescale 1ns / 1ps

module fel_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [1:0]                    operation,
    input  logic [fel_pkg::START_W-1:0]   start_req,
    input  logic [fel_pkg::AMT_W-1:0]     amount,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [2:0]                    status,
    input  logic [fel_pkg::START_W-1:0]   found_start,
    input  logic [fel_pkg::LEN_W-1:0]     found_length,
    input  logic [fel_pkg::COUNT_W-1:0]   entry_count,
    output int                            fail_count,
    output int                            pending
);

    localparam int DEPTH = 64;

    typedef struct packed {
        logic [2:0]                  st;
        logic [fel_pkg::START_W-1:0] fstart;
        logic [fel_pkg::LEN_W-1:0]   flen;
        logic [fel_pkg::COUNT_W-1:0] cnt;
    } fel_result_t;

    // shadow copy of the extent table
    logic [31:0] ext_base [DEPTH];
    logic [31:0] ext_len [DEPTH];
    int          ext_cnt;
    logic        seq_mode;
    fel_result_t result_q [$];

    function automatic int first_at_or_after(logic [31:0] key);
        int i;
        i = 0;
        while (i < ext_cnt && ext_base[i] < key)
            i++;
        return i;
    endfunction

    task automatic drop_entry(int pos);
        for (int i = pos; i + 1 < ext_cnt; i++)
        begin
            ext_base[i] = ext_base[i + 1];
            ext_len[i] = ext_len[i + 1];
        end
        ext_cnt--;
    endtask

    function automatic logic [31:0] sat_len(logic [33:0] v);
        return (v > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    task automatic add_extent(logic [31:0] req, logic [15:0] amt, output logic [2:0] st);
        int   pos;
        logic has_next, has_prev, join_next, join_prev;
        logic [32:0] req_end, prev_end;
        pos = first_at_or_after(req);
        has_next = pos < ext_cnt;
        has_prev = pos > 0;
        req_end = {1'b0, req} + amt;
        prev_end = has_prev ? {1'b0, ext_base[pos-1]} + ext_len[pos-1] : '0;
        join_next = 0;
        join_prev = 0;
        st = fel_pkg::ST_OK;
        if (has_next && ext_base[pos] == req)
        begin
            st = fel_pkg::ST_CONFLICT;
            return;
        end
        if (seq_mode)
        begin
            if ((has_next && {1'b0, ext_base[pos]} < req_end) ||
                (has_prev && prev_end > {1'b0, req}))
            begin
                st = fel_pkg::ST_CONFLICT;
                return;
            end
            join_next = has_next && {1'b0, ext_base[pos]} == req_end;
            join_prev = has_prev && prev_end == {1'b0, req};
        end
        if (join_prev && join_next)
        begin
            ext_len[pos-1] = sat_len({2'b0, ext_len[pos-1]} + amt + ext_len[pos]);
            drop_entry(pos);
        end
        else if (join_prev)
            ext_len[pos-1] = sat_len({2'b0, ext_len[pos-1]} + amt);
        else if (join_next)
        begin
            ext_base[pos] = req;
            ext_len[pos] = sat_len({2'b0, ext_len[pos]} + amt);
        end
        else if (ext_cnt >= DEPTH)
            st = fel_pkg::ST_FULL;
        else
        begin
            for (int i = ext_cnt; i > pos; i--)
            begin
                ext_base[i] = ext_base[i-1];
                ext_len[i] = ext_len[i-1];
            end
            ext_base[pos] = req;
            ext_len[pos] = 32'(amt);
            ext_cnt++;
        end
    endtask

    // work out the result of one request and update the shadow table
    task automatic apply_request(logic [1:0] op, logic [31:0] req, logic [15:0] amt);
        fel_result_t r;
        int pos;
        r = '0;
        r.st = fel_pkg::ST_OK;
        pos = first_at_or_after(req);
        case (op)
            fel_pkg::OP_ADD:
                add_extent(req, amt, r.st);
            fel_pkg::OP_USE:
                if (pos >= ext_cnt || ext_base[pos] != req)
                    r.st = fel_pkg::ST_NOT_FOUND;
                else if (ext_len[pos] < amt)
                    r.st = fel_pkg::ST_TOO_LARGE;
                else
                begin
                    ext_len[pos] = ext_len[pos] - amt;
                    r.flen = ext_len[pos];
                    if (seq_mode)
                    begin
                        if (ext_len[pos] == 0)
                            drop_entry(pos);
                        else
                            ext_base[pos] = ext_base[pos] + amt;
                    end
                end
            fel_pkg::OP_FIND:
            begin
                r.st = fel_pkg::ST_NOT_FOUND;
                for (int i = 0; i < ext_cnt; i++)
                begin
                    if (ext_len[i] >= amt)
                    begin
                        r.st = fel_pkg::ST_OK;
                        r.fstart = ext_base[i];
                        break;
                    end
                end
            end
            default:
                if (pos < ext_cnt && ext_base[pos] == req)
                    r.flen = ext_len[pos];
                else
                    r.st = fel_pkg::ST_NOT_FOUND;
        endcase
        r.cnt = ext_cnt[fel_pkg::COUNT_W-1:0];
        result_q = {result_q, r};
    endtask

    // watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        fel_result_t e;
        if (!rst_n)
        begin
            ext_cnt = 0;
            seq_mode = 1'b1;
            fail_count = 0;
            result_q.delete();
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && paddr == 3'd0)
                seq_mode = pwdata[0];
            if (in_valid && !in_stall)
                apply_request(operation, start_req, amount);
            if (out_valid && !out_stall)
            begin
                if (result_q.size() == 0)
                begin
                    $error("result with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    e = result_q.pop_front();
                    if (status !== e.st)
                    begin
                        $error("status exp %0d got %0d", e.st, status);
                        fail_count++;
                    end
                    if (found_start !== e.fstart)
                    begin
                        $error("found_start exp %h got %h", e.fstart, found_start);
                        fail_count++;
                    end
                    if (found_length !== e.flen)
                    begin
                        $error("found_length exp %h got %h", e.flen, found_length);
                        fail_count++;
                    end
                    if (entry_count !== e.cnt)
                    begin
                        $error("entry_count exp %0d got %0d", e.cnt, entry_count);
                        fail_count++;
                    end
                end
            end
            pending = result_q.size();
        end
    end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                          clk;
    logic                          rst_n;
    logic                          psel, penable, pwrite;
    logic [2:0]                    paddr;
    logic [31:0]                   pwdata, prdata;
    logic                          pready;
    logic                          in_valid, in_stall;
    logic [1:0]                    operation;
    logic [fel_pkg::START_W-1:0]   start_req;
    logic [fel_pkg::AMT_W-1:0]     amount;
    logic                          out_valid, out_stall;
    logic [2:0]                    status;
    logic [fel_pkg::START_W-1:0]   found_start;
    logic [fel_pkg::LEN_W-1:0]     found_length;
    logic [fel_pkg::COUNT_W-1:0]   entry_count;
    int                            fail_count, pending, idle_cycles, stall_left;
    logic                          sink_calm;

    free_extent_list DUT (.*);

    fel_checker u_checker (.*);

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // result-side stall pattern, mostly short runs and a few long ones
    always @(negedge clk)
    begin
        if (sink_calm)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 99) < 30)
        begin
            out_stall  <= 1'b1;
            stall_left <= pick_gap();
        end
        else
            out_stall <= 1'b0;
    end

    // watchdog on accepted traffic
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_request(logic [1:0] op, logic [31:0] req, logic [15:0] amt);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        start_req <= req;
        amount <= amt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_mode(logic m);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'd0;
        pwdata <= {31'b0, m};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // mostly well formed traffic around a small address window
    task automatic random_phase(int n, logic [31:0] base);
        logic [1:0]  op;
        logic [31:0] req;
        logic [15:0] amt;
        int r;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            op = 2'($urandom_range(0, 3));
            if (r < 70)
                req = base + $urandom_range(0, 4000);
            else if (r < 80)
                req = base + 32'($urandom_range(0, 40)) * 100;
            else
                req = $urandom;
            if ($urandom_range(0, 9) < 7)
                amt = 16'($urandom_range(0, 200));
            else
                amt = 16'($urandom);
            send_request(op, req, amt);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        in_valid = 0; operation = fel_pkg::OP_ADD; start_req = '0; amount = '0;
        out_stall = 0; sink_calm = 0; idle_cycles = 0; stall_left = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty table, extremes, merges, overflow, use edge cases
        send_request(fel_pkg::OP_FIND, 32'h0, 16'h0);
        send_request(fel_pkg::OP_QUERY, 32'h0, 16'h0);
        send_request(fel_pkg::OP_USE, 32'h0, 16'h0);
        send_request(fel_pkg::OP_ADD, 32'h1000, 16'd100);
        send_request(fel_pkg::OP_ADD, 32'h1000, 16'd5);
        send_request(fel_pkg::OP_ADD, 32'h1050, 16'd5);
        send_request(fel_pkg::OP_ADD, 32'h0FF0, 16'd32);
        send_request(fel_pkg::OP_ADD, 32'h1064, 16'd16);
        send_request(fel_pkg::OP_ADD, 32'h0FF0, 16'd0);
        send_request(fel_pkg::OP_ADD, 32'h0F00, 16'd240);
        send_request(fel_pkg::OP_ADD, 32'h2000, 16'hFFFF);
        send_request(fel_pkg::OP_ADD, 32'hFFFF_0000, 16'hFFFF);
        send_request(fel_pkg::OP_ADD, 32'hFFFF_FFFF, 16'd1);
        send_request(fel_pkg::OP_ADD, 32'h0, 16'd0);
        send_request(fel_pkg::OP_FIND, 32'h0, 16'hFFFF);
        send_request(fel_pkg::OP_FIND, 32'h0, 16'd0);
        send_request(fel_pkg::OP_USE, 32'h2000, 16'hFFFF);
        send_request(fel_pkg::OP_USE, 32'h0F00, 16'hFFFF);
        send_request(fel_pkg::OP_USE, 32'hFFFF_0000, 16'h0FFF);
        send_request(fel_pkg::OP_USE, 32'hFFFF_0FFF, 16'hF000);
        send_request(fel_pkg::OP_QUERY, 32'hFFFF_0FFF, 16'h0);
        send_request(fel_pkg::OP_USE, 32'h1234, 16'd1);

        // block mode: no merge, zero lengths kept
        write_mode(1'b0);
        send_request(fel_pkg::OP_ADD, 32'h5000, 16'd10);
        send_request(fel_pkg::OP_ADD, 32'h500A, 16'd10);
        send_request(fel_pkg::OP_USE, 32'h5000, 16'd10);
        send_request(fel_pkg::OP_QUERY, 32'h5000, 16'd0);
        random_phase(300, 32'h0001_0000);

        // sender pauses until the table is quiet
        drain();
        write_mode(1'b1);
        random_phase(300, 32'h0002_0000);

        // fill the table to its limit, then a merge that joins two neighbors
        for (int k = 0; k < 70; k++)
            send_request(fel_pkg::OP_ADD, 32'h8000_0000 + k * 32'h0001_0000, 16'hFFFF);
        send_request(fel_pkg::OP_ADD, 32'h8000_FFFF, 16'd1);
        send_request(fel_pkg::OP_ADD, 32'h9000_0000, 16'd1);
        random_phase(100, 32'h8000_0000);

        write_mode(1'b0);
        sink_calm = 1;
        random_phase(150, 32'h0003_0000);
        sink_calm = 0;
        write_mode(1'b1);
        random_phase(300, 32'h0004_0000);

        drain();
        repeat (20) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
